// ===== src/itdf2_pkg.sv =====
// shared constants, payload types and sequencer codes for the transposed df2 iir filter
// no dependencies
package itdf2_pkg;

    localparam int MAX_TAPS   = 8;
    localparam int COEF_W     = 24;
    localparam int SAMPLE_W   = 24;
    localparam int STATE_W    = 48;
    localparam int ORDER_W    = 4;
    localparam int INDEX_W    = 4;
    localparam int PROD_SHIFT = 19;

    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int DIFF_W = PROD_W + 1;
    localparam int ACC_W  = STATE_W + 1;
    localparam int K_W    = $clog2(MAX_TAPS + 2);
    localparam int CF_AW  = $clog2(MAX_TAPS + 1);
    localparam int ST_AW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] ADDR_ORDER   = PADDR_W'(0);
    localparam logic [ORDER_W-1:0] ORDER_RESET  = ORDER_W'(2);
    localparam logic [ORDER_W-1:0] ORDER_MIN    = ORDER_W'(1);
    localparam logic [ORDER_W-1:0] ORDER_MAX    = ORDER_W'(MAX_TAPS);
    localparam logic [INDEX_W-1:0] COEF_LAST    = INDEX_W'(MAX_TAPS);
    localparam logic [INDEX_W-1:0] STATE_DEPTH  = INDEX_W'(MAX_TAPS);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [STATE_W-1:0]  STATE_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0]  STATE_MIN  = {1'b1, {(STATE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_LOAD_A = 2'd2,
        MODE_LOAD_Z = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                     mode;
        logic [INDEX_W-1:0]        tap_index;
        logic signed [STATE_W-1:0] load_value;
        logic signed [SAMPLE_W-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_YMUL,
        S_YSUM,
        S_TAP,
        S_DONE
    } t_seq_state;

    typedef struct packed {
        logic mul_en;
        logic upper_en;
    } t_mac_ctrl;

endpackage

// ===== src/itdf2_mac.sv =====
// shared multiply-accumulate: registered b*x and a*y products, output and state update
// depends on itdf2_pkg
module itdf2_mac (
    input  logic                                  i_clk,
    input  itdf2_pkg::t_mac_ctrl                  i_ctrl,
    input  logic signed [itdf2_pkg::COEF_W-1:0]   i_coef_b,
    input  logic signed [itdf2_pkg::COEF_W-1:0]   i_coef_a,
    input  logic signed [itdf2_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [itdf2_pkg::SAMPLE_W-1:0] i_y,
    input  logic signed [itdf2_pkg::STATE_W-1:0]  i_upper,
    output logic signed [itdf2_pkg::SAMPLE_W-1:0] o_y,
    output logic                                  o_y_hit,
    output logic signed [itdf2_pkg::STATE_W-1:0]  o_z
);
    import itdf2_pkg::*;

    logic signed [PROD_W-1:0]  r_pb;
    logic signed [PROD_W-1:0]  r_pa;
    logic signed [STATE_W-1:0] r_upper;

    logic signed [ACC_W-1:0]   y_acc;
    logic signed [STATE_W-1:0] y_half;
    logic                      y_ovf;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  diff_sh;
    logic signed [ACC_W-1:0]   z_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_pb    <= i_coef_b * i_x;
            r_pa    <= i_coef_a * i_y;
            r_upper <= i_ctrl.upper_en ? i_upper : '0;
        end
    end

    // output sample: floor to 24 fraction bits, add z0, drop one more bit, saturate
    always_comb begin
        y_acc  = ACC_W'(r_pb >>> PROD_SHIFT) + ACC_W'(r_upper);
        y_half = y_acc[ACC_W-1:1];
        y_ovf  = (y_half[STATE_W-1:SAMPLE_W-1] != {(STATE_W-SAMPLE_W+1){y_half[STATE_W-1]}});
        if (y_ovf) begin
            o_y = y_half[STATE_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            o_y = y_half[SAMPLE_W-1:0];
        end
        o_y_hit = y_ovf;
    end

    // state update: exact difference, floor shift, add upper word, saturate
    always_comb begin
        diff    = DIFF_W'(r_pb) - DIFF_W'(r_pa);
        diff_sh = diff >>> PROD_SHIFT;
        z_acc   = ACC_W'(diff_sh) + ACC_W'(r_upper);
        if (z_acc[ACC_W-1] != z_acc[ACC_W-2]) begin
            o_z = z_acc[ACC_W-1] ? STATE_MIN : STATE_MAX;
        end else begin
            o_z = z_acc[STATE_W-1:0];
        end
    end

endmodule

// ===== src/iir_filter_transposed_df2.sv =====
// top level of the transposed df2 iir filter: sequencer, coefficient and state memories
// depends on itdf2_pkg and itdf2_mac
//
// A sample transaction keeps the block from accepting another until it is done: the
// taps are walked one per cycle through the coefficient and state memories, whose
// reads are registered, and the shared multiply-accumulate adds a product register
// and a write-back stage. Load transactions produce no result. The finished sample
// sits in an output register, so the next transaction is accepted while it waits
// to be taken.
// Coefficients are expected already normalized (a0 taken as one).
module iir_filter_transposed_df2 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  itdf2_pkg::t_in_item                i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output itdf2_pkg::t_out_item               o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [itdf2_pkg::PADDR_W-1:0]      paddr,
    input  logic [itdf2_pkg::PDATA_W-1:0]      pwdata,
    output logic [itdf2_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import itdf2_pkg::*;

    logic [2*COEF_W-1:0]      r_coef_mem  [MAX_TAPS+1];
    logic [STATE_W-1:0]       r_state_mem [MAX_TAPS];
    logic [MAX_TAPS:0]        r_b_vld;
    logic [MAX_TAPS:0]        r_a_vld;
    logic [MAX_TAPS-1:0]      r_z_vld;
    logic [2*COEF_W-1:0]      r_coef_rd;
    logic [STATE_W-1:0]       r_state_rd;
    logic                     r_b_ok;
    logic                     r_a_ok;
    logic                     r_z_ok;

    logic [ORDER_W-1:0]       r_order;
    t_seq_state               r_state;
    t_seq_state               n_state;
    logic [K_W-1:0]           r_rk;
    logic [K_W-1:0]           n_rk;
    logic                     r_q_vld;
    logic                     n_q_vld;
    logic [K_W-1:0]           r_qk;
    logic [K_W-1:0]           n_qk;
    logic                     r_p_vld;
    logic [K_W-1:0]           r_pk;
    logic                     r_out_vld;
    t_out_item                r_out;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [ORDER_W-1:0]       r_n;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                     r_hit;

    logic                     in_acc;
    logic                     cfg_wr;
    logic [ORDER_W-1:0]       cfg_order;
    logic                     load_out;
    logic                     take_y;
    t_mac_ctrl                mac_ctrl;
    logic [CF_AW-1:0]         rd_cf_addr;
    logic [ST_AW-1:0]         rd_st_addr;
    logic [CF_AW-1:0]         ld_cf_addr;
    logic [ST_AW-1:0]         ld_st_addr;
    logic                     ld_b_en;
    logic                     ld_a_en;
    logic                     ld_z_en;
    logic                     tap_wr_en;
    logic [ST_AW-1:0]         tap_wr_addr;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [STATE_W-1:0] state_q;
    logic signed [SAMPLE_W-1:0] mac_y;
    logic                     mac_y_hit;
    logic signed [STATE_W-1:0] mac_z;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ORDER);
    assign prdata = (paddr == ADDR_ORDER) ? PDATA_W'(r_order) : '0;

    always_comb begin
        cfg_order = pwdata[ORDER_W-1:0];
        if (cfg_order < ORDER_MIN) begin
            cfg_order = ORDER_MIN;
        end else if (cfg_order > ORDER_MAX) begin
            cfg_order = ORDER_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (cfg_wr) begin
            r_order <= cfg_order;
        end
    end

    // load decode
    assign in_acc     = i_in_valid && o_in_ready;
    assign ld_cf_addr = i_in_data.tap_index[CF_AW-1:0];
    assign ld_st_addr = i_in_data.tap_index[ST_AW-1:0];
    assign ld_b_en    = in_acc && (i_in_data.mode == MODE_LOAD_B)
                        && (i_in_data.tap_index <= COEF_LAST);
    assign ld_a_en    = in_acc && (i_in_data.mode == MODE_LOAD_A)
                        && (i_in_data.tap_index <= COEF_LAST);
    assign ld_z_en    = in_acc && (i_in_data.mode == MODE_LOAD_Z)
                        && (i_in_data.tap_index < STATE_DEPTH);

    assign tap_wr_en   = r_p_vld;
    assign tap_wr_addr = ST_AW'(r_pk - K_W'(1));
    assign rd_cf_addr  = r_rk[CF_AW-1:0];
    assign rd_st_addr  = r_rk[ST_AW-1:0];

    // memories
    always_ff @(posedge i_clk) begin
        if (ld_b_en) begin
            r_coef_mem[ld_cf_addr][2*COEF_W-1:COEF_W] <= i_in_data.load_value[COEF_W-1:0];
        end
        if (ld_a_en) begin
            r_coef_mem[ld_cf_addr][COEF_W-1:0] <= i_in_data.load_value[COEF_W-1:0];
        end
        r_coef_rd <= r_coef_mem[rd_cf_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tap_wr_en) begin
            r_state_mem[tap_wr_addr] <= mac_z;
        end else if (ld_z_en) begin
            r_state_mem[ld_st_addr] <= i_in_data.load_value;
        end
        r_state_rd <= r_state_mem[rd_st_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= '0;
            r_a_vld <= '0;
            r_z_vld <= '0;
            r_b_ok  <= 1'b0;
            r_a_ok  <= 1'b0;
            r_z_ok  <= 1'b0;
        end else begin
            if (ld_b_en) begin
                r_b_vld[ld_cf_addr] <= 1'b1;
            end
            if (ld_a_en) begin
                r_a_vld[ld_cf_addr] <= 1'b1;
            end
            if (tap_wr_en) begin
                r_z_vld[tap_wr_addr] <= 1'b1;
            end else if (ld_z_en) begin
                r_z_vld[ld_st_addr] <= 1'b1;
            end
            r_b_ok <= r_b_vld[rd_cf_addr];
            r_a_ok <= r_a_vld[rd_cf_addr];
            r_z_ok <= r_z_vld[rd_st_addr];
        end
    end

    assign coef_b  = r_b_ok ? r_coef_rd[2*COEF_W-1:COEF_W] : '0;
    assign coef_a  = r_a_ok ? r_coef_rd[COEF_W-1:0] : '0;
    assign state_q = r_z_ok ? r_state_rd : '0;

    itdf2_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_coef_b (coef_b),
        .i_coef_a (coef_a),
        .i_x      (r_x),
        .i_y      (r_y),
        .i_upper  (state_q),
        .o_y      (mac_y),
        .o_y_hit  (mac_y_hit),
        .o_z      (mac_z)
    );

    // sequencer
    always_comb begin
        n_state         = r_state;
        n_rk            = r_rk;
        n_q_vld         = 1'b0;
        n_qk            = r_qk;
        o_in_ready      = 1'b0;
        load_out        = 1'b0;
        take_y          = 1'b0;
        mac_ctrl.mul_en   = r_q_vld;
        mac_ctrl.upper_en = (r_qk < K_W'(r_n));
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_rk       = '0;
                if (i_in_valid && (i_in_data.mode == MODE_SAMPLE)) begin
                    n_state = S_YMUL;
                end
            end
            S_YMUL: begin
                mac_ctrl.mul_en   = 1'b1;
                mac_ctrl.upper_en = 1'b1;
                n_rk              = K_W'(1);
                n_state           = S_YSUM;
            end
            S_YSUM: begin
                take_y  = 1'b1;
                n_q_vld = 1'b1;
                n_qk    = r_rk;
                n_rk    = r_rk + K_W'(1);
                n_state = S_TAP;
            end
            S_TAP: begin
                if (r_rk <= K_W'(r_n)) begin
                    n_q_vld = 1'b1;
                    n_qk    = r_rk;
                    n_rk    = r_rk + K_W'(1);
                end else if (!r_q_vld) begin
                    n_rk    = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rk      <= '0;
            r_q_vld   <= 1'b0;
            r_qk      <= '0;
            r_p_vld   <= 1'b0;
            r_pk      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rk    <= n_rk;
            r_q_vld <= n_q_vld;
            r_qk    <= n_qk;
            r_p_vld <= r_q_vld;
            r_pk    <= r_qk;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_data.mode == MODE_SAMPLE)) begin
            r_x <= i_in_data.sample_in;
            r_n <= r_order;
        end
        if (take_y) begin
            r_y   <= mac_y;
            r_hit <= mac_y_hit;
        end
        if (load_out) begin
            r_out.sample_out <= r_y;
            r_out.saturated  <= r_hit;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // checks
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_q_vld && !r_p_vld))
        else $error("tap pipeline busy while idle");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP && tap_wr_en && r_rk <= K_W'(r_n)) |-> (tap_wr_addr != rd_st_addr))
        else $error("state write collides with state read");

    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_order >= ORDER_MIN) && (r_order <= ORDER_MAX))
        else $error("order register out of range");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_out_ready) |=> (r_out_vld && $stable(r_out)))
        else $error("pending result overwritten");

    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> ((r_pk >= K_W'(1)) && (r_pk <= K_W'(r_n))))
        else $error("state write outside active taps");

endmodule
